// ===== hw/rtl/mqsb_pkg.sv =====
package mqsb_pkg;

    // Sizing of the shared store
    localparam int SLOTS      = 16;
    localparam int QUEUES     = 4;
    localparam int DATA_WIDTH = 32;

    // Slot index, pointer (one extra code for null) and queue index widths
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

    // Command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               command;
        logic [1:0]         queue_id;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
    } out_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // word accepted: update pointers, access data store
        logic load_out;  // capture the result into the output register
    } dp_cmd_t;

    // A pointer names a slot when it is below the null code
    function automatic logic is_slot(input logic [PTR_W-1:0] ptr);
        return ptr < NULL_PTR;
    endfunction

endpackage

// ===== hw/rtl/mqsb_ram.sv =====
module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/mqsb_ctrl.sv =====
module mqsb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output mqsb_pkg::dp_cmd_t cmd
);

    import mqsb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic start;
    logic load;

    // Take a word only between operations
    assign s_ready = (state_reg == ST_IDLE);
    assign start   = s_valid && s_ready;
    // Result moves out once the output register is free or being drained
    assign load    = (state_reg == ST_READ) && (!m_valid_reg || m_ready);

    assign cmd.start    = start;
    assign cmd.load_out = load;
    assign m_valid      = m_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/mqsb_datapath.sv =====
module mqsb_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  mqsb_pkg::dp_cmd_t cmd,
    input  mqsb_pkg::in_word_t s_word,
    output mqsb_pkg::out_word_t m_word
);

    import mqsb_pkg::*;

    logic [PTR_W-1:0] link_reg [SLOTS];
    logic [PTR_W-1:0] link_next [SLOTS];
    logic [PTR_W-1:0] head_reg [QUEUES];
    logic [PTR_W-1:0] head_next [QUEUES];
    logic [PTR_W-1:0] tail_reg [QUEUES];
    logic [PTR_W-1:0] tail_next [QUEUES];
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] free_head_next;

    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             deq_ok_reg;
    out_word_t        out_reg;

    logic [QIDX_W-1:0] qidx;
    logic              q_ok;
    logic [PTR_W-1:0]  head_cur;
    logic [PTR_W-1:0]  tail_cur;
    logic [PTR_W-1:0]  head_link;
    logic [PTR_W-1:0]  free_link;
    logic              enq_ok;
    logic              deq_ok;

    logic                  ram_we;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic signed [DATA_WIDTH-1:0] rdata_s;

    // Decode the addressed queue and the pointers it touches
    assign qidx      = QIDX_W'(s_word.queue_id);
    assign q_ok      = 32'(s_word.queue_id) < QUEUES;
    assign head_cur  = head_reg[qidx];
    assign tail_cur  = tail_reg[qidx];
    assign head_link = link_reg[head_cur[SLOT_W-1:0]];
    assign free_link = link_reg[free_head_reg[SLOT_W-1:0]];

    assign enq_ok = (s_word.command == CMD_ENQ) && q_ok && is_slot(free_head_reg);
    assign deq_ok = (s_word.command == CMD_DEQ) && q_ok && is_slot(head_cur);

    // Pointer and link updates, all in the accept cycle
    always_comb begin
        link_next      = link_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        status_next    = (s_word.command == CMD_ENQ) ? ST_FULL : ST_EMPTY;
        if (cmd.start && enq_ok) begin
            free_head_next = free_link;
            if (!is_slot(head_cur)) begin
                head_next[qidx] = free_head_reg;
            end else if (is_slot(tail_cur)) begin
                link_next[tail_cur[SLOT_W-1:0]] = free_head_reg;
            end
            tail_next[qidx] = free_head_reg;
            link_next[free_head_reg[SLOT_W-1:0]] = NULL_PTR;
            status_next = ST_OK;
        end else if (cmd.start && deq_ok) begin
            head_next[qidx] = is_slot(head_link) ? head_link : NULL_PTR;
            if (!is_slot(head_link)) begin
                tail_next[qidx] = NULL_PTR;
            end
            link_next[head_cur[SLOT_W-1:0]] = free_head_reg;
            free_head_next = head_cur;
            status_next = ST_OK;
        end
    end

    // Data store: enqueue writes, dequeue reads the head slot
    assign ram_we    = cmd.start && enq_ok;
    assign ram_waddr = free_head_reg[SLOT_W-1:0];
    assign ram_wdata = DATA_WIDTH'(s_word.value);
    assign ram_re    = cmd.start && deq_ok;
    assign ram_raddr = head_cur[SLOT_W-1:0];

    mqsb_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(SLOTS)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Free list chains every slot at reset; all queues empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                link_reg[i] <= PTR_W'(i + 1);
            end
            for (int i = 0; i < QUEUES; i++) begin
                head_reg[i] <= NULL_PTR;
                tail_reg[i] <= NULL_PTR;
            end
            free_head_reg <= '0;
        end else begin
            link_reg      <= link_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
        end
    end

    // Per-operation result bits, held until the output register takes them
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            status_reg <= status_next;
            deq_ok_reg <= deq_ok;
        end
    end

    // Output register
    assign rdata_s = ram_rdata;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.status     <= status_reg;
            out_reg.read_value <= deq_ok_reg ? 32'(rdata_s) : 32'sd0;
        end
    end

    assign m_word = out_reg;

endmodule

// ===== hw/rtl/multi_queue_shared_buffer_core.sv =====
// Several FIFO queues sharing one slot store through per-slot links and a
// single free list.
// Input channel (s_valid/s_ready/s_word): one command word per operation,
//   enqueue of value into queue_id, or dequeue from queue_id.
// Result channel (m_valid/m_ready/m_word): exactly one word per command,
//   status ok/full/empty and the dequeued value (0 when none).
// Each command: the accepting edge updates the pointers and registers the
//   store read; in ST_READ, with s_ready low, the result moves into the
//   output register, raising m_valid, once that register is free or being drained.
// The output register lets the next command in while a result waits; if
//   the receiver stalls longer, s_ready stays low after that command until
//   its result can move into the output register. Nothing is dropped.
// Reset (aresetn, synchronous, active low): all queues empty, every slot on
//   the free list in order, no result pending. The store contents are not
//   cleared; only slots written by an enqueue are ever read back.
module multi_queue_shared_buffer_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mqsb_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output mqsb_pkg::out_word_t m_word
);

    import mqsb_pkg::*;

    dp_cmd_t cmd;

    mqsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mqsb_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_word  (s_word),
        .m_word  (m_word)
    );

endmodule

// ===== bench/mqsb_check_pkg.sv =====
package mqsb_check_pkg;
    import mqsb_pkg::*;

    // Tracks every queue's linked list and the result words the core still owes
    class shared_queue_scoreboard;
        logic signed [31:0] slot_data [SLOTS];
        logic [PTR_W-1:0]   slot_link [SLOTS];
        logic [PTR_W-1:0]   head_ptr  [QUEUES];
        logic [PTR_W-1:0]   tail_ptr  [QUEUES];
        logic [PTR_W-1:0]   free_ptr;
        out_word_t          owed_words [$];
        int                 mismatches;
        int                 results_seen;

        // Reset image: free list chains all slots in order, every queue empty
        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_data[i] = '0;
                slot_link[i] = PTR_W'(i + 1);
            end
            for (int i = 0; i < QUEUES; i++) begin
                head_ptr[i] = NULL_PTR;
                tail_ptr[i] = NULL_PTR;
            end
            free_ptr     = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function bit names_slot(input logic [PTR_W-1:0] ptr);
            return ptr < NULL_PTR;
        endfunction

        function int outstanding();
            return owed_words.size();
        endfunction

        // Update the list state for one command and return the word it owes
        function out_word_t apply_command(input in_word_t w);
            out_word_t        r;
            logic [PTR_W-1:0] slot;
            logic [PTR_W-1:0] nxt;
            int               q;
            r.status     = ST_OK;
            r.read_value = '0;
            q = int'(w.queue_id);
            if (w.command == CMD_ENQ) begin
                slot = free_ptr;
                if (q >= QUEUES || !names_slot(slot)) begin
                    r.status = ST_FULL;
                end else begin
                    free_ptr = slot_link[slot[SLOT_W-1:0]];
                    if (!names_slot(head_ptr[q])) begin
                        head_ptr[q] = slot;
                    end else if (names_slot(tail_ptr[q])) begin
                        slot_link[tail_ptr[q][SLOT_W-1:0]] = slot;
                    end
                    tail_ptr[q] = slot;
                    slot_link[slot[SLOT_W-1:0]] = NULL_PTR;
                    slot_data[slot[SLOT_W-1:0]] = w.value;
                end
            end else begin
                if (q >= QUEUES || !names_slot(head_ptr[q])) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot = head_ptr[q];
                    nxt  = slot_link[slot[SLOT_W-1:0]];
                    head_ptr[q] = names_slot(nxt) ? nxt : NULL_PTR;
                    if (!names_slot(nxt)) begin
                        tail_ptr[q] = NULL_PTR;
                    end
                    slot_link[slot[SLOT_W-1:0]] = free_ptr;
                    free_ptr     = slot;
                    r.read_value = slot_data[slot[SLOT_W-1:0]];
                end
            end
            return r;
        endfunction

        task note_command(input in_word_t w);
            owed_words.push_back(apply_command(w));
        endtask

        // One line per mismatch
        task report_mismatch(input string what);
            $display("mismatch at result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task check_result(input out_word_t got);
            out_word_t want;
            results_seen++;
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d data=%h",
                                          got.status, got.read_value));
                return;
            end
            want = owed_words.pop_front();
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
            end
            if (got.read_value !== want.read_value) begin
                report_mismatch($sformatf("read_value got %h want %h",
                                          got.read_value, want.read_value));
            end
        endtask
    endclass

endpackage

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mqsb_pkg::*;
    import mqsb_check_pkg::*;

    localparam int RANDOM_WORDS = 1075;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [31:0] CORNER_VALUES [8] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    bit steady_run   = 1'b0;
    int quiet_cycles = 0;

    shared_queue_scoreboard sb = new();

    multi_queue_shared_buffer_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Handshake monitor: check delivered words, then note accepted commands
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_word);
            if (s_valid && s_ready) sb.note_command(s_word);
        end
    end

    // Receiver backpressure, off during the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady_run || ($urandom_range(99) >= 23);
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("multi_queue_shared_buffer_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command word; returns at the edge where it is taken
    task automatic send_word(input logic cmd, input logic [1:0] qid,
                             input logic [31:0] val);
        in_word_t w;
        w.command  = cmd;
        w.queue_id = qid;
        w.value    = val;
        if (!steady_run) begin
            while ($urandom_range(99) < 23) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every owed word has arrived
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    // Empty dequeues, fill every slot, overflow, then drain one queue
    task automatic run_directed();
        for (int q = 0; q < QUEUES; q++) begin
            send_word(CMD_DEQ, 2'(q), $urandom());
        end
        for (int i = 0; i < SLOTS; i++) begin
            send_word(CMD_ENQ, 2'(i % QUEUES), (i < 8) ? CORNER_VALUES[i] : $urandom());
        end
        send_word(CMD_ENQ, 2'd2, 32'h1234_5678);
        for (int i = 0; i < 4; i++) begin
            send_word(CMD_DEQ, 2'd1, 32'h0);
        end
    endtask

    // Phases biased toward filling, draining or balance, often on one queue
    task automatic run_random(input int count);
        int               left_in_phase;
        int               enq_pct;
        int               focus_q;
        logic             cmd;
        logic [1:0]       qid;
        logic [31:0]      val;
        left_in_phase = 0;
        enq_pct       = 50;
        focus_q       = -1;
        for (int n = 0; n < count; n++) begin
            if (n == 400) steady_run <= 1'b1;
            if (n == 650) steady_run <= 1'b0;
            if (n == 700) wait_for_drain();
            if (left_in_phase == 0) begin
                left_in_phase = $urandom_range(60, 15);
                case ($urandom_range(2))
                    0: enq_pct = 80;
                    1: enq_pct = 20;
                    default: enq_pct = 50;
                endcase
                focus_q = ($urandom_range(1) == 0) ? int'($urandom_range(QUEUES - 1)) : -1;
            end
            left_in_phase--;
            cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            if (focus_q >= 0 && $urandom_range(99) < 75) begin
                qid = 2'(focus_q);
            end else begin
                qid = 2'($urandom_range(QUEUES - 1));
            end
            if ($urandom_range(99) < 30) begin
                val = CORNER_VALUES[$urandom_range(7)];
            end else begin
                val = $urandom();
            end
            send_word(cmd, qid, val);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        wait_for_drain();
        run_random(RANDOM_WORDS);
        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("multi_queue_shared_buffer_core regression: pass");
        end else begin
            $display("multi_queue_shared_buffer_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mqsb_pkg.sv
hw/rtl/mqsb_ram.sv
hw/rtl/mqsb_ctrl.sv
hw/rtl/mqsb_datapath.sv
hw/rtl/multi_queue_shared_buffer_core.sv
bench/mqsb_check_pkg.sv
bench/tb.sv
